[src/pixel_blend_unit_core_defines.svh]
// ---------------------------------------------------------------------------
// pixel_blend_unit_core_defines
// Assertion macros used by the pixel blend unit core RTL.
// ---------------------------------------------------------------------------
`ifndef PIXEL_BLEND_UNIT_CORE_DEFINES_SVH
`define PIXEL_BLEND_UNIT_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PBU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel blend unit check failed");

// next-cycle implication, clocked on clk, off during reset
`define PBU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel blend unit check failed");

`endif

[src/pbu_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbu_pkg
// Types, codes and lane masks for the pixel blend unit pipeline.
// ---------------------------------------------------------------------------
package pbu_pkg;

  // operation codes on the request
  localparam logic [2:0] FUNC_COPY      = 3'd0;
  localparam logic [2:0] FUNC_FILL      = 3'd1;
  localparam logic [2:0] FUNC_BLEND_SRC = 3'd2;
  localparam logic [2:0] FUNC_BLEND_FG  = 3'd3;
  localparam logic [2:0] FUNC_ADD_SAT   = 3'd4;

  // pixel formats
  localparam logic [2:0] BPP_8     = 3'd1;
  localparam logic [2:0] BPP_565   = 3'd2;
  localparam logic [2:0] BPP_24    = 3'd3;
  localparam logic [2:0] BPP_32    = 3'd4;
  localparam logic [2:0] BPP_RESET = BPP_32;

  localparam logic [23:0] MASK_565_R = 24'h00F800;
  localparam logic [23:0] MASK_565_G = 24'h0007E0;
  localparam logic [23:0] MASK_565_B = 24'h00001F;
  localparam logic [23:0] MASK_PK_RB = 24'hFF00FF;
  localparam logic [23:0] MASK_PK_G  = 24'h00FF00;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] dst_pixel;
    logic [31:0] src_pixel;
    logic [31:0] fg_color;
    logic [7:0]  weight_src;
    logic [7:0]  weight_dst;
    logic        end_of_run;
  } in_req_t;

  typedef struct packed {
    logic [31:0] out_pixel;
    logic        end_of_run_out;
  } out_rsp_t;

  // decoded operation carried down the pipe
  typedef enum logic [2:0] {
    OP_DST,
    OP_OTH,
    OP_BL565,
    OP_BLPK,
    OP_ADD565,
    OP_ADDB
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] mask;
    logic [31:0] dst;
    logic [31:0] oth;
    logic [7:0]  ws;
    logic [7:0]  wd;
    logic        eor;
  } s1_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] mask;
    logic [31:0] pd_a;
    logic [31:0] ps_a;
    logic [31:0] pd_b;
    logic [31:0] ps_b;
    logic [31:0] pd_c;
    logic [31:0] ps_c;
    logic [31:0] simple;
    logic        eor;
  } s2_t;

  typedef struct packed {
    logic [23:0] a;
    logic [23:0] b;
    logic [23:0] c;
  } lane_masks_t;

  function automatic lane_masks_t lane_masks(op_t op);
    lane_masks_t m;
    m = '0;
    case (op)
      OP_BL565: begin
        m.a = MASK_565_R;
        m.b = MASK_565_G;
        m.c = MASK_565_B;
      end
      OP_BLPK: begin
        m.a = MASK_PK_RB;
        m.b = MASK_PK_G;
      end
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

[src/pbu_decode.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbu_decode
// First stage: resolve operation and format into an op code and width mask.
// ---------------------------------------------------------------------------
module pbu_decode
  import pbu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] bpp,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_req_t    in_req,
  output logic       out_valid,
  input  logic       out_ready,
  output s1_t        out_dat
);

  logic v_r;
  s1_t  dat_r;
  s1_t  dat_nxt;
  logic fmt_ok;
  logic wide;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_dat   = dat_r;

  always_comb begin
    fmt_ok = bpp inside {[BPP_8:BPP_32]};
    wide   = (bpp == BPP_24) || (bpp == BPP_32);

    dat_nxt.dst = in_req.dst_pixel;
    dat_nxt.ws  = in_req.weight_src;
    dat_nxt.wd  = in_req.weight_dst;
    dat_nxt.eor = in_req.end_of_run;
    dat_nxt.oth = (in_req.func == FUNC_FILL || in_req.func == FUNC_BLEND_FG) ?
                  in_req.fg_color : in_req.src_pixel;

    case (bpp)
      BPP_8:   dat_nxt.mask = 32'h0000_00FF;
      BPP_565: dat_nxt.mask = 32'h0000_FFFF;
      BPP_24:  dat_nxt.mask = 32'h00FF_FFFF;
      default: dat_nxt.mask = 32'hFFFF_FFFF;
    endcase

    dat_nxt.op = OP_DST;
    if (fmt_ok) begin
      case (in_req.func)
        FUNC_COPY, FUNC_FILL: dat_nxt.op = OP_OTH;
        FUNC_BLEND_SRC, FUNC_BLEND_FG: begin
          if (bpp == BPP_565) dat_nxt.op = OP_BL565;
          else if (wide)      dat_nxt.op = OP_BLPK;
        end
        FUNC_ADD_SAT: begin
          if (bpp == BPP_565) dat_nxt.op = OP_ADD565;
          else if (wide)      dat_nxt.op = OP_ADDB;
        end
        default: dat_nxt.op = OP_DST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dat_r <= dat_nxt;
    end
  end

endmodule

[src/pbu_mult.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbu_mult
// Second stage: weight products per channel group and saturating add.
// ---------------------------------------------------------------------------
module pbu_mult
  import pbu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  s1_t  in_dat,
  output logic out_valid,
  input  logic out_ready,
  output s2_t  out_dat
);

  logic        v_r;
  s2_t         dat_r;
  s2_t         dat_nxt;
  lane_masks_t lm;

  function automatic logic [31:0] mul_lane(logic [31:0] px, logic [23:0] m,
                                           logic [7:0] w);
    logic [31:0] a;
    a = {8'd0, px[23:0] & m};
    return a * {24'd0, w};
  endfunction

  function automatic logic [31:0] add_565(logic [31:0] d, logic [31:0] s);
    logic [5:0] b;
    logic [6:0] g;
    logic [5:0] r;
    b = {1'b0, d[4:0]} + {1'b0, s[4:0]};
    g = {1'b0, d[10:5]} + {1'b0, s[10:5]};
    r = {1'b0, d[15:11]} + {1'b0, s[15:11]};
    return {16'd0, (r[5] ? 5'h1F : r[4:0]), (g[6] ? 6'h3F : g[5:0]),
            (b[5] ? 5'h1F : b[4:0])};
  endfunction

  function automatic logic [31:0] add_bytes(logic [31:0] d, logic [31:0] s);
    logic [31:0] res;
    logic [8:0]  t;
    res = '0;
    for (int i = 0; i < 4; i++) begin
      t = {1'b0, d[8*i +: 8]} + {1'b0, s[8*i +: 8]};
      res[8*i +: 8] = t[8] ? 8'hFF : t[7:0];
    end
    return res;
  endfunction

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_dat   = dat_r;

  always_comb begin
    lm = lane_masks(in_dat.op);
    dat_nxt.op   = in_dat.op;
    dat_nxt.mask = in_dat.mask;
    dat_nxt.eor  = in_dat.eor;
    dat_nxt.pd_a = mul_lane(in_dat.dst, lm.a, in_dat.wd);
    dat_nxt.ps_a = mul_lane(in_dat.oth, lm.a, in_dat.ws);
    dat_nxt.pd_b = mul_lane(in_dat.dst, lm.b, in_dat.wd);
    dat_nxt.ps_b = mul_lane(in_dat.oth, lm.b, in_dat.ws);
    dat_nxt.pd_c = mul_lane(in_dat.dst, lm.c, in_dat.wd);
    dat_nxt.ps_c = mul_lane(in_dat.oth, lm.c, in_dat.ws);
    case (in_dat.op)
      OP_OTH:    dat_nxt.simple = in_dat.oth;
      OP_ADD565: dat_nxt.simple = add_565(in_dat.dst, in_dat.oth);
      // 24-bit drops the top byte through the format mask
      OP_ADDB:   dat_nxt.simple = add_bytes(in_dat.dst, in_dat.oth);
      default:   dat_nxt.simple = in_dat.dst;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dat_r <= dat_nxt;
    end
  end

endmodule

[src/pbu_merge.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pbu_merge
// Third stage: sum products, shift, mask channels and form the result.
// ---------------------------------------------------------------------------
module pbu_merge
  import pbu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  s2_t      in_dat,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_rsp
);

  logic        v_r;
  out_rsp_t    dat_r;
  out_rsp_t    dat_nxt;
  lane_masks_t lm;
  logic [31:0] sum_a;
  logic [31:0] sum_b;
  logic [31:0] sum_c;
  logic [31:0] blend;

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_rsp   = dat_r;

  always_comb begin
    lm = lane_masks(in_dat.op);
    // sums wrap at 32 bits before the shift
    sum_a = in_dat.pd_a + in_dat.ps_a;
    sum_b = in_dat.pd_b + in_dat.ps_b;
    sum_c = in_dat.pd_c + in_dat.ps_c;
    blend = ((sum_a >> 8) & {8'd0, lm.a}) |
            ((sum_b >> 8) & {8'd0, lm.b}) |
            ((sum_c >> 8) & {8'd0, lm.c});
    if (in_dat.op == OP_BL565 || in_dat.op == OP_BLPK) begin
      dat_nxt.out_pixel = blend & in_dat.mask;
    end else begin
      dat_nxt.out_pixel = in_dat.simple & in_dat.mask;
    end
    dat_nxt.end_of_run_out = in_dat.eor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dat_r <= dat_nxt;
    end
  end

endmodule

[src/pixel_blend_unit_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pixel_blend_unit_core
// Per-pixel write-back: copy, fill, weighted blend and saturating add.
// ---------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request: operation, destination, source,
//   foreground color, two weights and an end-of-run flag.
//   out_valid/out_ready carry one result pixel per request, in order.
//   cfg_we/cfg_wdata set the pixel format (bytes per pixel); write it only
//   while no request is in flight. Reset sets the format to 32-bit.
//   A request passes through the registered stages in order: decode, weight
//   multiply, then sum/shift/mask into the output register. Throughput is one
//   pixel per cycle while out_ready is high; each stage holds one pixel and
//   advances when the stage after it is empty or moving.
//   When the receiver stalls, the result holds in the output register and
//   up to two more requests are taken into the empty upstream stages
//   before in_ready drops. Reset empties all stages.
// ---------------------------------------------------------------------------
`include "pixel_blend_unit_core_defines.svh"

module pixel_blend_unit_core
  import pbu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_req_t    in_req,
  output logic       out_valid,
  input  logic       out_ready,
  output out_rsp_t   out_rsp
);

  logic [2:0] bpp_r;
  logic       s1_valid;
  logic       s1_ready;
  s1_t        s1_dat;
  logic       s2_valid;
  logic       s2_ready;
  s2_t        s2_dat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= BPP_RESET;
    end else if (cfg_we) begin
      bpp_r <= cfg_wdata;
    end
  end

  pbu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .bpp       (bpp_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_dat   (s1_dat)
  );

  pbu_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_dat    (s1_dat),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_dat   (s2_dat)
  );

  pbu_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_dat    (s2_dat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  // full pipe with a stalled receiver must refuse new requests
  `PBU_ASSERT_IMP(a_full_blocks, s1_valid && s2_valid && out_valid && !out_ready, !in_ready)
  // an accepted request lands in the first stage
  `PBU_ASSERT_NXT(a_accept_lands, in_valid && in_ready, s1_valid)
  // a stalled middle stage keeps its pixel
  `PBU_ASSERT_NXT(a_mid_holds, s2_valid && !s2_ready, s2_valid && $stable(s2_dat))

endmodule
